>>> rtl/asw_pkg.sv
// Shared types and constants of the asymmetric slew smoother.
// No dependencies; every other file of the block imports this package.
package asw_pkg;

    localparam int DEF_SAMPLE_BITS = 24;
    localparam int DEF_COEFF_BITS  = 32;
    localparam int FILT_BITS       = 32;
    localparam int HT_BITS         = 40;
    localparam int MUL_AW          = 41;
    localparam int DIG_BITS        = 8;
    localparam int CFG_IDX_BITS    = 3;
    localparam int EXP_STEPS       = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RISE_HALFTIME    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FALL_HALFTIME    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_INERTIA_HALFTIME = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SNAP_THRESHOLD   = 3'd4;

    localparam logic [31:0] RST_SAMPLE_PERIOD    = 32'd97391;
    localparam logic [31:0] RST_RISE_HALFTIME    = 32'd167772160;
    localparam logic [31:0] RST_FALL_HALFTIME    = 32'd1677722;
    localparam logic [31:0] RST_INERTIA_HALFTIME = 32'd16777;
    localparam logic [23:0] RST_SNAP_THRESHOLD   = 24'd1678;

    localparam logic [1:0] MUL_EXP   = 2'd0;
    localparam logic [1:0] MUL_INERT = 2'd1;
    localparam logic [1:0] MUL_FILT  = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       div_start;
        logic       coef_main;
        logic       exp_init;
        logic       mul_start;
        logic [1:0] mul_mode;
        logic       r_update;
        logic       k_inc;
        logic       coef_store;
        logic       mov_update;
        logic       snap;
        logic       filt_update;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic ivalid;
        logic need_main;
        logic frac_bit;
        logic k_last;
        logic out_free;
    } t_stat;

    // Root factor c_k of the exp2 product: c_1 is one half, each next one is
    // the square root of the previous. Evaluated at elaboration only.
    function automatic logic [63:0] f_root_factor(input int k, input int cb);
        logic [95:0] n;
        logic [95:0] t;
        logic [95:0] res;
        logic [63:0] c;
        c = 64'd1 << (cb - 1);
        for (int i = 1; i < k; i++) begin
            n   = 96'(c) << cb;
            res = '0;
            for (int b = cb; b >= 0; b--) begin
                t = res | (96'd1 << b);
                if (t * t <= n) begin
                    res = t;
                end
            end
            c = res[63:0];
        end
        return c;
    endfunction

endpackage

>>> rtl/asw_if.sv
// Channel interfaces of the asymmetric slew smoother: sample in, sample out
// and the configuration write channel. Depends on asw_pkg.
interface asw_in_if import asw_pkg::*; #(parameter int W = DEF_SAMPLE_BITS) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface asw_out_if import asw_pkg::*; #(parameter int W = DEF_SAMPLE_BITS) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

interface asw_cfg_if import asw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [31:0]             data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/asw_div.sv
// Restoring divider, one quotient bit per cycle: (dividend << 32) / divisor.
// Depends on asw_pkg.
module asw_div import asw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_dividend,
    input  logic [HT_BITS-1:0] i_divisor,
    output logic               o_done,
    output logic [63:0]        o_quo
);

    logic [HT_BITS-1:0] r_rem;
    logic [63:0]        r_dvd;
    logic [HT_BITS-1:0] r_dvs;
    logic [6:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [HT_BITS:0]   rem_sh;
    logic [HT_BITS:0]   rem_sub;
    logic               ge;

    assign rem_sh  = {r_rem, r_dvd[63]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient bits shift in where the dividend bits leave.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= {i_dividend, 32'd0};
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[HT_BITS-1:0] : rem_sh[HT_BITS-1:0];
            r_dvd <= {r_dvd[62:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dvd;

endmodule

>>> rtl/asw_mul.sv
// Digit-serial multiplier, one 8-bit digit of the second operand per cycle,
// most significant digit first. Depends on asw_pkg.
module asw_mul import asw_pkg::*; #(
    parameter  int BW = DEF_COEFF_BITS + 1,
    localparam int ND = (BW + DIG_BITS - 1) / DIG_BITS,
    localparam int PW = MUL_AW + ND * DIG_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MUL_AW-1:0] i_a,
    input  logic [BW-1:0]     i_b,
    output logic              o_done,
    output logic [PW-1:0]     o_prod
);

    localparam int CW = $clog2(ND + 1);

    logic [MUL_AW-1:0]          r_a;
    logic [ND*DIG_BITS-1:0]     r_b;
    logic [PW-1:0]              r_acc;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [MUL_AW+DIG_BITS-1:0] pp;

    assign pp = {{DIG_BITS{1'b0}}, r_a}
              * {{MUL_AW{1'b0}}, r_b[ND*DIG_BITS-1 -: DIG_BITS]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ND);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= (ND*DIG_BITS)'(i_b);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= (r_acc << DIG_BITS) + PW'(pp);
            r_b   <= r_b << DIG_BITS;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

>>> rtl/asw_dp.sv
// Datapath of the asymmetric slew smoother: configuration registers, filter
// state, coefficient evaluation and output register. Depends on asw_pkg,
// asw_div and asw_mul.
module asw_dp import asw_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int COEFF_BITS  = DEF_COEFF_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    localparam int CB = COEFF_BITS;
    localparam int SB = SAMPLE_BITS;
    localparam int GB = FILT_BITS - SAMPLE_BITS;
    localparam int BW = CB + 1;
    localparam int ND = (BW + DIG_BITS - 1) / DIG_BITS;
    localparam int PW = MUL_AW + ND * DIG_BITS;
    localparam logic [CB:0]   COEFF_ONE = (CB+1)'(1) << CB;
    localparam logic [PW-1:0] RND_HALF  = PW'(1) << (CB - 1);
    localparam logic [32:0]   OUT_HALF  = (33'd1 << GB) >> 1;
    localparam logic [32:0]   OUT_TOP   = (33'd1 << SB) - 33'd1;

    // Configuration and coefficient cache
    logic [31:0]         r_period;
    logic [31:0]         r_rise;
    logic [31:0]         r_fall;
    logic [31:0]         r_inert_ht;
    logic [23:0]         r_snap;
    logic                r_ivalid;
    logic                r_hvalid;
    logic [CB-1:0]       r_icoef;
    logic [CB-1:0]       r_mcoef;
    logic [HT_BITS-1:0]  r_mark;

    // Per-sample state
    logic signed [SB-1:0] r_last;
    logic                 r_falling;
    logic signed [SB-1:0] r_x;
    logic [HT_BITS-1:0]   r_target;
    logic [HT_BITS-1:0]   r_mov;
    logic [HT_BITS-1:0]   r_used;
    logic signed [31:0]   r_filt;

    // Coefficient evaluation
    logic [HT_BITS-1:0] r_ht;
    logic [CB:0]        r_r;
    logic [4:0]         r_k;
    logic               r_zero;

    logic                 r_ovalid;
    logic signed [SB-1:0] r_odata;

    logic [CB-1:0]      c_tab [EXP_STEPS];
    logic [HT_BITS-1:0] ht_sel;
    logic               div_done;
    logic [63:0]        quo;
    logic               mul_done;
    logic [PW-1:0]      prod;
    logic [PW-1:0]      prod_rnd;
    logic [MUL_AW-1:0]  mres;
    logic [MUL_AW-1:0]  mul_a;
    logic [BW-1:0]      mul_b;
    logic               n_falling;
    logic               mov_gt;
    logic [HT_BITS-1:0] mov_d;
    logic signed [32:0] xf;
    logic signed [32:0] fe;
    logic               filt_gt;
    logic [32:0]        filt_d;
    logic [5:0]         ip;
    logic [CB+1:0]      half_v;
    logic [CB+1:0]      rsum;
    logic [CB+1:0]      ashift;
    logic [CB-1:0]      coef_v;
    logic [32:0]        osum;
    logic [32:0]        ocode;

    for (genvar g = 0; g < EXP_STEPS; g++) begin : g_ctab
        assign c_tab[g] = CB'(f_root_factor(g + 1, CB));
    end

    assign ht_sel = i_cmd.coef_main ? r_used : {r_inert_ht, 8'd0};

    asw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_period),
        .i_divisor  (ht_sel),
        .o_done     (div_done),
        .o_quo      (quo)
    );

    // Operand selection of the shared multiplier
    assign mov_gt  = r_target > r_mov;
    assign mov_d   = mov_gt ? r_target - r_mov : r_mov - r_target;
    assign xf      = 33'(r_x) <<< GB;
    assign fe      = 33'(r_filt);
    assign filt_gt = xf > fe;
    assign filt_d  = filt_gt ? 33'(xf - fe) : 33'(fe - xf);

    always_comb begin
        case (i_cmd.mul_mode)
            MUL_INERT: begin
                mul_a = MUL_AW'(mov_d);
                mul_b = COEFF_ONE - {1'b0, r_icoef};
            end
            MUL_FILT: begin
                mul_a = MUL_AW'(filt_d);
                mul_b = COEFF_ONE - {1'b0, r_mcoef};
            end
            default: begin
                mul_a = MUL_AW'(r_r);
                mul_b = {1'b0, c_tab[r_k]};
            end
        endcase
    end

    asw_mul #(.BW(BW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    assign prod_rnd = prod + RND_HALF;
    assign mres     = prod_rnd[CB +: MUL_AW];

    // Final scaling of the exp2 product by the whole part of the exponent
    assign ip     = quo[37:32];
    assign half_v = ((CB+2)'(1) << ip) >> 1;
    assign rsum   = {1'b0, r_r} + half_v;
    assign ashift = rsum >> ip;
    always_comb begin
        if (r_zero) begin
            coef_v = '0;
        end else if (ashift[CB+1:CB] != 2'b00) begin
            coef_v = '1;
        end else begin
            coef_v = ashift[CB-1:0];
        end
    end

    assign n_falling = (i_sample > r_last) ? 1'b0 :
                       (i_sample < r_last) ? 1'b1 : r_falling;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= RST_SAMPLE_PERIOD;
            r_rise     <= RST_RISE_HALFTIME;
            r_fall     <= RST_FALL_HALFTIME;
            r_inert_ht <= RST_INERTIA_HALFTIME;
            r_snap     <= RST_SNAP_THRESHOLD;
            r_ivalid   <= 1'b0;
            r_hvalid   <= 1'b0;
            r_icoef    <= '0;
            r_mcoef    <= '0;
            r_last     <= '0;
            r_falling  <= 1'b0;
            r_mov      <= '0;
            r_filt     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SAMPLE_PERIOD: begin
                        r_period <= i_cfg_data;
                        r_ivalid <= 1'b0;
                        r_hvalid <= 1'b0;
                    end
                    REG_RISE_HALFTIME: r_rise <= i_cfg_data;
                    REG_FALL_HALFTIME: r_fall <= i_cfg_data;
                    REG_INERTIA_HALFTIME: begin
                        r_inert_ht <= i_cfg_data;
                        r_ivalid   <= 1'b0;
                    end
                    REG_SNAP_THRESHOLD: r_snap <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_in) begin
                r_last    <= i_sample;
                r_falling <= n_falling;
            end
            if (i_cmd.coef_store) begin
                if (i_cmd.coef_main) begin
                    r_mcoef  <= coef_v;
                    r_hvalid <= 1'b1;
                end else begin
                    r_icoef  <= coef_v;
                    r_ivalid <= 1'b1;
                end
            end
            if (i_cmd.mov_update) begin
                r_mov <= mov_gt ? r_mov + mres[HT_BITS-1:0] : r_mov - mres[HT_BITS-1:0];
            end
            if (i_cmd.filt_update) begin
                r_filt <= filt_gt ? 32'(fe + $signed({1'b0, mres[32:0]}))
                                  : 32'(fe - $signed({1'b0, mres[32:0]}));
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Output rounding: offset to unsigned, round half up, limit to top code
    assign osum  = {1'b0, ~r_filt[31], r_filt[30:0]} + OUT_HALF;
    assign ocode = ((osum >> GB) > OUT_TOP) ? OUT_TOP : (osum >> GB);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x      <= i_sample;
            r_target <= {n_falling ? r_fall : r_rise, 8'd0};
        end
        if (i_cmd.div_start) begin
            r_ht <= ht_sel;
        end
        if (i_cmd.exp_init) begin
            r_r    <= COEFF_ONE;
            r_k    <= '0;
            r_zero <= (r_ht == '0) || (quo[63:32] >= 32'd63);
        end else begin
            if (i_cmd.r_update) begin
                r_r <= mres[CB:0];
            end
            if (i_cmd.k_inc) begin
                r_k <= r_k + 5'd1;
            end
        end
        if (i_cmd.coef_store && i_cmd.coef_main) begin
            r_mark <= r_ht;
        end
        if (i_cmd.snap) begin
            r_used <= (mov_d < {8'd0, r_snap, 8'd0}) ? r_target : r_mov;
        end
        if (i_cmd.out_load) begin
            r_odata <= {~ocode[SB-1], ocode[SB-2:0]};
        end
    end

    assign o_stat.div_done  = div_done;
    assign o_stat.mul_done  = mul_done;
    assign o_stat.ivalid    = r_ivalid;
    assign o_stat.need_main = !r_hvalid || (r_used != r_mark);
    assign o_stat.frac_bit  = quo[{1'b0, ~r_k}];
    assign o_stat.k_last    = &r_k;
    assign o_stat.out_free  = !r_ovalid || i_ready;

    assign o_valid  = r_ovalid;
    assign o_sample = r_odata;

endmodule

>>> rtl/asw_ctrl.sv
// Sequencer of the asymmetric slew smoother: steps one sample through the
// coefficient updates and both filters. Depends on asw_pkg.
module asw_ctrl import asw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DSTART = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_EXPI   = 4'd3;
    localparam logic [3:0] S_BIT    = 4'd4;
    localparam logic [3:0] S_MULW   = 4'd5;
    localparam logic [3:0] S_FIN    = 4'd6;
    localparam logic [3:0] S_INERT  = 4'd7;
    localparam logic [3:0] S_INERTW = 4'd8;
    localparam logic [3:0] S_SNAP   = 4'd9;
    localparam logic [3:0] S_CHK    = 4'd10;
    localparam logic [3:0] S_FILT   = 4'd11;
    localparam logic [3:0] S_FILTW  = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_main;
    logic       n_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_main  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_main  <= n_main;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_main         = r_main;
        o_cmd          = '0;
        o_cmd.coef_main = r_main;
        o_cmd.mul_mode = MUL_EXP;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_main        = 1'b0;
                    n_state       = i_stat.ivalid ? S_INERT : S_DSTART;
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_EXPI;
                end
            end
            S_EXPI: begin
                o_cmd.exp_init = 1'b1;
                n_state        = S_BIT;
            end
            // One fraction bit of the exponent per visit; set bits multiply in
            // their root factor.
            S_BIT: begin
                if (i_stat.frac_bit) begin
                    o_cmd.mul_start = 1'b1;
                    n_state         = S_MULW;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    if (i_stat.k_last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_MULW: begin
                if (i_stat.mul_done) begin
                    o_cmd.r_update = 1'b1;
                    o_cmd.k_inc    = 1'b1;
                    n_state        = i_stat.k_last ? S_FIN : S_BIT;
                end
            end
            S_FIN: begin
                o_cmd.coef_store = 1'b1;
                n_state          = r_main ? S_FILT : S_INERT;
            end
            S_INERT: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_mode  = MUL_INERT;
                n_state         = S_INERTW;
            end
            S_INERTW: begin
                o_cmd.mul_mode = MUL_INERT;
                if (i_stat.mul_done) begin
                    o_cmd.mov_update = 1'b1;
                    n_state          = S_SNAP;
                end
            end
            S_SNAP: begin
                o_cmd.snap = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                if (i_stat.need_main) begin
                    n_main  = 1'b1;
                    n_state = S_DSTART;
                end else begin
                    n_state = S_FILT;
                end
            end
            S_FILT: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_mode  = MUL_FILT;
                n_state         = S_FILTW;
            end
            S_FILTW: begin
                o_cmd.mul_mode = MUL_FILT;
                if (i_stat.mul_done) begin
                    o_cmd.filt_update = 1'b1;
                    n_state           = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> rtl/asymmetric_slew_smoother.sv
// Top level of the asymmetric slew smoother.
// Depends on asw_pkg, the channel interfaces in asw_if, asw_ctrl and asw_dp.
//
// Usage: samples arrive on i_in (valid/ready), smoothed samples leave on
// o_out, one result per input transfer, in order. Registers are written on
// i_cfg (index 0 sample period, 1 rise, 2 fall, 3 inertia half-time,
// 4 snap threshold; higher indices are ignored); it is always ready. The user must
// write it only while no sample is in flight; the block does not enforce this.
// Each coefficient evaluation runs a 64-step serial divide and the 32 exp2
// steps, plus a multiply for every set fraction bit of the exponent, where
// the 8-bit digit-serial multiplier sets the pace. One sample is processed
// at a time; the next transfer is taken as soon as the previous result sits
// in the output register, even if the receiver has not yet taken it.
// A stalled receiver holds the result in the output register; processing
// then waits at the end of the next sample until that register is free.
// Reset is synchronous: registers return to their default values, all
// filter state clears and both coefficients are recomputed on first use.
module asymmetric_slew_smoother import asw_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int COEFF_BITS  = DEF_COEFF_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    asw_in_if.sink       i_in,
    asw_out_if.source    o_out,
    asw_cfg_if.sink      i_cfg
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    asw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    asw_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_sample    (i_in.sample_in),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_sample    (o_out.sample_out)
    );

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

endmodule
